@@ hdl/tps_pkg.sv @@
package tps_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned LaneLat = DiffW + 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0] diff_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t slice_height;
  } tri_t;

  typedef struct packed {
    logic   hit;
    coord_t seg_a_x;
    coord_t seg_a_y;
    coord_t seg_b_x;
    coord_t seg_b_y;
  } seg_t;

endpackage

@@ hdl/tps_lane.sv @@
module tps_lane (
  input  logic            clk_i,
  input  logic            en_i,
  input  tps_pkg::diff_t  a_i,
  input  tps_pkg::diff_t  b_i,
  input  tps_pkg::diff_t  d_i,
  input  tps_pkg::coord_t p_i,
  output tps_pkg::coord_t res_o
);

  localparam int unsigned W = tps_pkg::DiffW;

  logic [W-1:0] am_q, bm_q, dm_q, dx_q;
  logic neg_q, negx_q;
  tps_pkg::coord_t pm_q, px_q;
  logic [tps_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q <= a_i[W-1] ? W'(-a_i) : W'(a_i);
      bm_q <= b_i[W-1] ? W'(-b_i) : W'(b_i);
      dm_q <= d_i[W-1] ? W'(-d_i) : W'(d_i);
      neg_q <= (a_i[W-1] ^ b_i[W-1]) ^ d_i[W-1];
      pm_q <= p_i;
      prod_q <= am_q * bm_q;
      dx_q <= dm_q;
      negx_q <= neg_q;
      px_q <= pm_q;
    end
  end

  logic [W-1:0] r_q [W];
  logic [W-1:0] lo_q [W];
  logic [W-1:0] qt_q [W];
  logic [W-1:0] dv_q [W];
  logic neg_s_q [W];
  tps_pkg::coord_t p_s_q [W];

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W-1:0] r_in, lo_in, qt_in, d_in;
    logic neg_in;
    tps_pkg::coord_t p_in;
    logic [W:0] t, diff;
    if (k == 0) begin : g_first
      assign r_in = prod_q[2*W-1:W];
      assign lo_in = prod_q[W-1:0];
      assign qt_in = '0;
      assign d_in = dx_q;
      assign neg_in = negx_q;
      assign p_in = px_q;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign lo_in = lo_q[k-1];
      assign qt_in = qt_q[k-1];
      assign d_in = dv_q[k-1];
      assign neg_in = neg_s_q[k-1];
      assign p_in = p_s_q[k-1];
    end
    assign t = {r_in, lo_in[W-1]};
    assign diff = t - {1'b0, d_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t >= {1'b0, d_in}) begin
          r_q[k] <= diff[W-1:0];
          qt_q[k] <= {qt_in[W-2:0], 1'b1};
        end else begin
          r_q[k] <= t[W-1:0];
          qt_q[k] <= {qt_in[W-2:0], 1'b0};
        end
        lo_q[k] <= {lo_in[W-2:0], 1'b0};
        dv_q[k] <= d_in;
        neg_s_q[k] <= neg_in;
        p_s_q[k] <= p_in;
      end
    end
  end

  logic [W-1:0] pe, sum;
  assign pe = W'(p_s_q[W-1]);
  assign sum = neg_s_q[W-1] ? (pe - qt_q[W-1]) : (pe + qt_q[W-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= sum[tps_pkg::CoordW-1:0];
    end
  end

endmodule

@@ hdl/triangle_plane_slice.sv @@
// Cuts one triangle with the horizontal plane z = slice_height.
// The input channel carries one triangle and the height per beat; the
// output channel carries one result beat per input beat, in order.
// Each coordinate is signed Q16.16. A vertex with z at or above the
// height counts as above. When all vertices share a side, hit is low and
// the endpoints are zero; otherwise the two crossings of the edges are
// given in edge order 1-2, 1-3, 2-3 as endpoints A and B.
// One triangle is accepted every cycle while the pipeline does not hold.
// A result is shown once its input beat has passed 38 register stages: an
// input register, a difference stage, a magnitude stage, a multiply stage,
// 33 stages of a restoring divider that resolves one quotient bit each,
// and an output register. Four such lanes run side by side, one per output
// coordinate.
// Reset clears all valid bits; the pipeline then holds no beats.
// When the receiver stalls while a result is shown, the whole pipeline
// holds and stall_o is raised, so nothing is lost or repeated. Empty
// slots keep flowing while the output is not valid.
module triangle_plane_slice (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  tps_pkg::tri_t data_i,
  output logic          valid_o,
  input  logic          stall_i,
  output tps_pkg::seg_t data_o
);

  localparam int unsigned Depth = tps_pkg::LaneLat + 2;

  logic en;
  logic [Depth-1:0] vld_q;
  logic [Depth-1:1] hit_q;
  tps_pkg::tri_t in_q;

  assign en = !(vld_q[Depth-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= data_i;
    end
  end

  logic up0, up1, up2, e0, e1, e2, hit;
  tps_pkg::coord_t apx, apy, apz, aqx, aqy, aqz;
  tps_pkg::coord_t bpx, bpy, bpz, bqx, bqy, bqz;

  assign up0 = in_q.az >= in_q.slice_height;
  assign up1 = in_q.bz >= in_q.slice_height;
  assign up2 = in_q.cz >= in_q.slice_height;
  assign e0 = up0 ^ up1;
  assign e1 = up0 ^ up2;
  assign e2 = up1 ^ up2;
  assign hit = e0 || e1;

  always_comb begin
    if (e0) begin
      apx = in_q.ax; apy = in_q.ay; apz = in_q.az;
      aqx = in_q.bx; aqy = in_q.by; aqz = in_q.bz;
    end else begin
      apx = in_q.ax; apy = in_q.ay; apz = in_q.az;
      aqx = in_q.cx; aqy = in_q.cy; aqz = in_q.cz;
    end
    if (e0 && e1) begin
      bpx = in_q.ax; bpy = in_q.ay; bpz = in_q.az;
      bqx = in_q.cx; bqy = in_q.cy; bqz = in_q.cz;
    end else begin
      bpx = in_q.bx; bpy = in_q.by; bpz = in_q.bz;
      bqx = in_q.cx; bqy = in_q.cy; bqz = in_q.cz;
    end
  end

  tps_pkg::diff_t aa_q, bb_q, ad_q, bd_q, abx_q, aby_q, bbx_q, bby_q;
  tps_pkg::coord_t apx_q, apy_q, bpx_q, bpy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= {hit_q[Depth-2:1], hit};
      aa_q <= tps_pkg::DiffW'(in_q.slice_height) - tps_pkg::DiffW'(apz);
      bb_q <= tps_pkg::DiffW'(in_q.slice_height) - tps_pkg::DiffW'(bpz);
      ad_q <= tps_pkg::DiffW'(aqz) - tps_pkg::DiffW'(apz);
      bd_q <= tps_pkg::DiffW'(bqz) - tps_pkg::DiffW'(bpz);
      abx_q <= tps_pkg::DiffW'(aqx) - tps_pkg::DiffW'(apx);
      aby_q <= tps_pkg::DiffW'(aqy) - tps_pkg::DiffW'(apy);
      bbx_q <= tps_pkg::DiffW'(bqx) - tps_pkg::DiffW'(bpx);
      bby_q <= tps_pkg::DiffW'(bqy) - tps_pkg::DiffW'(bpy);
      apx_q <= apx;
      apy_q <= apy;
      bpx_q <= bpx;
      bpy_q <= bpy;
    end
  end

  tps_pkg::coord_t rax, ray, rbx, rby;

  tps_lane u_ax (.clk_i, .en_i(en), .a_i(aa_q), .b_i(abx_q), .d_i(ad_q), .p_i(apx_q),
                 .res_o(rax));
  tps_lane u_ay (.clk_i, .en_i(en), .a_i(aa_q), .b_i(aby_q), .d_i(ad_q), .p_i(apy_q),
                 .res_o(ray));
  tps_lane u_bx (.clk_i, .en_i(en), .a_i(bb_q), .b_i(bbx_q), .d_i(bd_q), .p_i(bpx_q),
                 .res_o(rbx));
  tps_lane u_by (.clk_i, .en_i(en), .a_i(bb_q), .b_i(bby_q), .d_i(bd_q), .p_i(bpy_q),
                 .res_o(rby));

  always_comb begin
    data_o.hit = hit_q[Depth-1];
    data_o.seg_a_x = hit_q[Depth-1] ? rax : '0;
    data_o.seg_a_y = hit_q[Depth-1] ? ray : '0;
    data_o.seg_b_x = hit_q[Depth-1] ? rbx : '0;
    data_o.seg_b_y = hit_q[Depth-1] ? rby : '0;
  end

endmodule

@@ bench/triangle_plane_slice_tb.sv @@
module triangle_plane_slice_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency = 38;
  localparam int unsigned CycleLimit = 400000;

  logic           clk_i;
  logic           rst_ni;
  logic           valid_i;
  logic           stall_o;
  tps_pkg::tri_t  data_i;
  logic           valid_o;
  logic           stall_i;
  tps_pkg::seg_t  data_o;

  tps_pkg::seg_t  expected_segs[$];
  int    mismatch_count;
  int    cycle_count;
  int    send_idle_pct;
  int    recv_stall_pct;

  triangle_plane_slice uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .data_i  (data_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .data_o  (data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint edge_cross(longint p, longint qv, longint pz, longint qz,
                                        longint h);
    logic signed [127:0] prod;
    logic signed [127:0] quot;
    prod = 128'(h - pz) * 128'(qv - p);
    if (qz == pz) return p;
    quot = prod / 128'(qz - pz);
    return p + longint'(quot);
  endfunction

  function automatic tps_pkg::seg_t slice_triangle(tps_pkg::tri_t t);
    tps_pkg::seg_t r;
    longint xs[3], ys[3], zs[3], h;
    longint cx[2], cy[2];
    bit up[3];
    int nup, n;
    int ep[3], eq[3];
    ep = '{0, 0, 1};
    eq = '{1, 2, 2};
    xs = '{longint'(t.ax), longint'(t.bx), longint'(t.cx)};
    ys = '{longint'(t.ay), longint'(t.by), longint'(t.cy)};
    zs = '{longint'(t.az), longint'(t.bz), longint'(t.cz)};
    h = longint'(t.slice_height);
    r = '0;
    nup = 0;
    n = 0;
    cx = '{0, 0};
    cy = '{0, 0};
    for (int i = 0; i < 3; i++) begin
      up[i] = zs[i] >= h;
      nup += up[i];
    end
    if (nup == 0 || nup == 3) return r;
    for (int e = 0; e < 3; e++) begin
      if (up[ep[e]] != up[eq[e]] && n < 2) begin
        cx[n] = edge_cross(xs[ep[e]], xs[eq[e]], zs[ep[e]], zs[eq[e]], h);
        cy[n] = edge_cross(ys[ep[e]], ys[eq[e]], zs[ep[e]], zs[eq[e]], h);
        n++;
      end
    end
    r.hit = 1'b1;
    r.seg_a_x = tps_pkg::coord_t'(cx[0]);
    r.seg_a_y = tps_pkg::coord_t'(cy[0]);
    r.seg_b_x = tps_pkg::coord_t'(cx[1]);
    r.seg_b_y = tps_pkg::coord_t'(cy[1]);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_triangle(tps_pkg::tri_t t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    data_i  <= t;
    expected_segs.push_back(slice_triangle(t));
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    stall_i <= rst_ni && recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
  end

  always @(posedge clk_i) begin
    tps_pkg::seg_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_segs.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_segs.pop_front();
        if (data_o.hit !== want.hit)
          report_mismatch($sformatf("hit %b want %b", data_o.hit, want.hit));
        if (data_o.seg_a_x !== want.seg_a_x)
          report_mismatch($sformatf("seg_a_x %h want %h", data_o.seg_a_x, want.seg_a_x));
        if (data_o.seg_a_y !== want.seg_a_y)
          report_mismatch($sformatf("seg_a_y %h want %h", data_o.seg_a_y, want.seg_a_y));
        if (data_o.seg_b_x !== want.seg_b_x)
          report_mismatch($sformatf("seg_b_x %h want %h", data_o.seg_b_x, want.seg_b_x));
        if (data_o.seg_b_y !== want.seg_b_y)
          report_mismatch($sformatf("seg_b_y %h want %h", data_o.seg_b_y, want.seg_b_y));
      end
    end
  end

  function automatic tps_pkg::coord_t rand_coord();
    case ($urandom_range(5))
      0: return tps_pkg::coord_t'($urandom_range(7) == 0 ? 32'h8000_0000 : 32'h7fff_ffff);
      1: return tps_pkg::coord_t'($urandom_range(2000) - 1000);
      2: return tps_pkg::coord_t'(($urandom_range(200) - 100) << 16);
      default: return tps_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic tps_pkg::tri_t rand_triangle();
    tps_pkg::tri_t t;
    t.ax = rand_coord();
    t.ay = rand_coord();
    t.az = rand_coord();
    t.bx = rand_coord();
    t.by = rand_coord();
    t.bz = rand_coord();
    t.cx = rand_coord();
    t.cy = rand_coord();
    t.cz = rand_coord();
    case ($urandom_range(9))
      0: t.slice_height = rand_coord();
      1: t.slice_height = t.az;
      2: t.slice_height = t.bz;
      3: t.slice_height = t.cz;
      default: begin
        // Pick a height midway between two vertex z values so the plane usually crosses.
        t.slice_height = tps_pkg::coord_t'((longint'(t.az) + longint'(t.bz)) >>> 1);
        if ($urandom_range(1)) t.slice_height = tps_pkg::coord_t'((longint'(t.bz) +
                                                                   longint'(t.cz)) >>> 1);
      end
    endcase
    return t;
  endfunction

  function automatic tps_pkg::tri_t make_triangle(int ax, int ay, int az, int bx, int by,
                                                  int bz, int cx, int cy, int cz, int h);
    tps_pkg::tri_t t;
    t = '{tps_pkg::coord_t'(ax), tps_pkg::coord_t'(ay), tps_pkg::coord_t'(az),
          tps_pkg::coord_t'(bx), tps_pkg::coord_t'(by), tps_pkg::coord_t'(bz),
          tps_pkg::coord_t'(cx), tps_pkg::coord_t'(cy), tps_pkg::coord_t'(cz),
          tps_pkg::coord_t'(h)};
    return t;
  endfunction

  task automatic test_directed();
    int unsigned mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send_triangle(make_triangle(0, 0, 1 << 16, 1 << 16, 0, 2 << 16, 0, 1 << 16, 3 << 16, 0));
    send_triangle(make_triangle(0, 0, -(1 << 16), 1, 1, -2, 2, 2, -3, 0));
    send_triangle(make_triangle(0, 0, 0, 4 << 16, 0, 4 << 16, 0, 4 << 16, -(4 << 16),
                                1 << 16));
    send_triangle(make_triangle(10, 20, 5, 30, 40, -5, 50, 60, -5, 0));
    send_triangle(make_triangle(10, 20, -5, 30, 40, 5, 50, 60, -5, 0));
    send_triangle(make_triangle(10, 20, -5, 30, 40, -5, 50, 60, 5, 0));
    send_triangle(make_triangle(1, 2, 0, 3, 4, -1, 5, 6, -1, 0));
    send_triangle(make_triangle(1, 2, 3, 3, 4, 3, 5, 6, 2, 3));
    send_triangle(make_triangle(mn, mn, mn, mx, mx, mx, mn, mx, mn, mx));
    send_triangle(make_triangle(mx, mn, mn, mn, mx, mx, mx, mx, mx, mn + 1));
    send_triangle(make_triangle(mn, mx, mx, mx, mn, mn, mn, mn, mn, 0));
    send_triangle(make_triangle(mx, mx, mn, mn, mn, mx, mx, mn, 0, 0));
    send_triangle(make_triangle(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_triangle(make_triangle(mx, mx, mx, mx, mx, mx, mx, mx, mx, mn));
    send_triangle(make_triangle(-7, 7, -3, 7, -7, 2, 0, 0, 2, 0));
    send_triangle(make_triangle(-1, -1, mn, -1, -1, mx, -1, -1, mx, -1));
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_triangle(rand_triangle());
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni  = 1'b0;
    valid_i = 1'b0;
    data_i  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(100, 0, 0);
    test_random(100, 62, 0);
    test_random(100, 0, 62);
    test_random(100, 36, 36);
    valid_i <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (expected_segs.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
